@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property checked while reset is released.
`define WRB_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked at every edge, reset included.
`define WRB_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WRB_ASSERT(name, clk, rst_n, prop, msg)
`define WRB_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

@@ rtl/wrb_pkg.sv @@
// ---------------------------------------------------------------------------
// Weighted random bag package
// Operation and status codes, sequencer states and fixed field widths.
// ---------------------------------------------------------------------------
package wrb_pkg;

    localparam int OP_W     = 3;
    localparam int KEYIN_W  = 16;
    localparam int AMT_W    = 16;
    localparam int RND_W    = 32;
    localparam int STAT_W   = 3;
    localparam int PCT_W    = 15;
    localparam int TOTOUT_W = 20;

    // percent times 256
    localparam int PCT_SCALE = 25600;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_DEL   = 3'd1,
        OP_CLEAR = 3'd2,
        OP_QUERY = 3'd3,
        OP_PICK  = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_INVALID  = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRD,
        S_SCMP,
        S_SHR,
        S_SHW,
        S_MOD,
        S_DIV,
        S_OUT
    } t_state;

endpackage

@@ rtl/wrb_div.sv @@
// ---------------------------------------------------------------------------
// Shift-subtract divider
// Restoring division, one quotient bit per cycle; used for both the
// modulo of a pick and the percentage of a query.
// ---------------------------------------------------------------------------
module wrb_div #(
    parameter int DVD_W = 32,
    parameter int DSR_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DSR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DSR_W-1:0] o_remainder
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;

    logic [DSR_W:0]   trial;
    logic [DSR_W:0]   diff;
    logic             qbit;
    logic [DSR_W-1:0] n_rem;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        diff  = trial - {1'b0, r_dsr};
        qbit  = (trial >= {1'b0, r_dsr});
        n_rem = qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], qbit};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule

@@ rtl/weighted_random_bag.sv @@
// ---------------------------------------------------------------------------
// Weighted random bag
// Ordered key/count table with add, delete, clear, share query and
// weighted pick (roulette wheel).
// ---------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | to block  | i_valid / o_ready  | operation, item_key, amount, random_value
// out     | from block| o_valid / i_ready  | status, picked_key, percent_fixed, total_count
//
// One item at a time. Table search and pick walk visit entries in order
// through one memory read port, a read state then a compare state per
// entry; delete that empties an entry then moves each later entry up.
// Pick and query add one pass of the shared divider. Clear and items
// rejected at the check step go straight to the result. The result is held
// until taken; reset empties the table at once, no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module weighted_random_bag #(
    parameter int ENTRIES    = 16,
    parameter int KEY_BITS   = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [15:0] i_item_key,
    input  logic [15:0] i_amount,
    input  logic [31:0] i_random_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [15:0] o_picked_key,
    output logic [14:0] o_percent_fixed,
    output logic [19:0] o_total_count
);

    localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int UW    = $clog2(ENTRIES + 1);
    localparam int TOT_W = COUNT_BITS + $clog2(ENTRIES);
    localparam int AW    = ((COUNT_BITS > wrb_pkg::AMT_W) ? COUNT_BITS : wrb_pkg::AMT_W) + 1;
    localparam int PRD_W = COUNT_BITS + wrb_pkg::PCT_W;
    localparam int DVD_W = (PRD_W > wrb_pkg::RND_W) ? PRD_W : wrb_pkg::RND_W;

    // table storage
    logic [KEY_BITS-1:0]   mem_key [ENTRIES];
    logic [COUNT_BITS-1:0] mem_cnt [ENTRIES];

    wrb_pkg::t_state r_state, n_state;
    logic [wrb_pkg::OP_W-1:0]   r_op, n_op;
    logic [KEY_BITS-1:0]        r_key, n_key;
    logic [wrb_pkg::AMT_W-1:0]  r_amt, n_amt;
    logic [wrb_pkg::RND_W-1:0]  r_rnd, n_rnd;
    logic [UW-1:0]              r_idx, n_idx;
    logic [UW-1:0]              r_used, n_used;
    logic [TOT_W-1:0]           r_total, n_total;
    logic [TOT_W-1:0]           r_rem, n_rem;
    logic [wrb_pkg::STAT_W-1:0] r_status, n_status;
    logic [KEY_BITS-1:0]        r_picked, n_picked;
    logic [wrb_pkg::PCT_W-1:0]  r_pct, n_pct;
    logic [KEY_BITS-1:0]        r_rd_key;
    logic [COUNT_BITS-1:0]      r_rd_cnt;

    logic [IW-1:0]         rd_addr;
    logic                  mem_we;
    logic [IW-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [COUNT_BITS-1:0] wr_cnt;

    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;
    logic [TOT_W-1:0] div_rem;

    logic             amt_bad;
    logic             tab_empty;
    logic             at_end;
    logic             key_hit;
    logic             pick_hit;
    logic [UW-1:0]    idx_inc;
    logic [AW-1:0]    amt_x;
    logic [AW-1:0]    cnt_x;
    logic [AW-1:0]    sum_x;
    logic [AW-1:0]    cmax_x;
    logic [TOT_W-1:0] cnt_t;
    logic [PRD_W-1:0] product;

    // shared compares
    always_comb begin
        amt_bad   = (r_amt == '0) || (r_key == '0);
        tab_empty = (r_used == '0) || (r_total == '0);
        at_end    = (r_idx == r_used);
        key_hit   = (r_rd_key == r_key);
        idx_inc   = r_idx + 1'b1;
        amt_x     = AW'(r_amt);
        cnt_x     = AW'(r_rd_cnt);
        sum_x     = cnt_x + amt_x;
        cmax_x    = AW'({COUNT_BITS{1'b1}});
        cnt_t     = TOT_W'(r_rd_cnt);
        pick_hit  = (r_rem < cnt_t);
        product   = PRD_W'(r_rd_cnt) * PRD_W'(wrb_pkg::PCT_SCALE);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrb_pkg::S_IDLE:
                if (i_valid) n_state = wrb_pkg::S_CHECK;
            wrb_pkg::S_CHECK: begin
                case (r_op)
                    wrb_pkg::OP_ADD:
                        n_state = amt_bad ? wrb_pkg::S_OUT : wrb_pkg::S_SRD;
                    wrb_pkg::OP_DEL:
                        n_state = (amt_bad || r_used == '0) ? wrb_pkg::S_OUT : wrb_pkg::S_SRD;
                    wrb_pkg::OP_QUERY:
                        n_state = tab_empty ? wrb_pkg::S_OUT : wrb_pkg::S_SRD;
                    wrb_pkg::OP_PICK:
                        n_state = tab_empty ? wrb_pkg::S_OUT : wrb_pkg::S_MOD;
                    default:
                        n_state = wrb_pkg::S_OUT;
                endcase
            end
            wrb_pkg::S_SRD:
                n_state = at_end ? wrb_pkg::S_OUT : wrb_pkg::S_SCMP;
            wrb_pkg::S_SCMP: begin
                if (r_op == wrb_pkg::OP_PICK) begin
                    n_state = pick_hit ? wrb_pkg::S_OUT : wrb_pkg::S_SRD;
                end else if (!key_hit) begin
                    n_state = wrb_pkg::S_SRD;
                end else if (r_op == wrb_pkg::OP_QUERY) begin
                    n_state = wrb_pkg::S_DIV;
                end else if (r_op == wrb_pkg::OP_DEL && amt_x == cnt_x) begin
                    n_state = wrb_pkg::S_SHR;
                end else begin
                    n_state = wrb_pkg::S_OUT;
                end
            end
            wrb_pkg::S_SHR:
                n_state = (idx_inc >= r_used) ? wrb_pkg::S_OUT : wrb_pkg::S_SHW;
            wrb_pkg::S_SHW:
                n_state = wrb_pkg::S_SHR;
            wrb_pkg::S_MOD:
                if (div_done) n_state = wrb_pkg::S_SRD;
            wrb_pkg::S_DIV:
                if (div_done) n_state = wrb_pkg::S_OUT;
            wrb_pkg::S_OUT:
                if (i_ready) n_state = wrb_pkg::S_IDLE;
            default:
                n_state = wrb_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op      = r_op;
        n_key     = r_key;
        n_amt     = r_amt;
        n_rnd     = r_rnd;
        n_idx     = r_idx;
        n_used    = r_used;
        n_total   = r_total;
        n_rem     = r_rem;
        n_status  = r_status;
        n_picked  = r_picked;
        n_pct     = r_pct;
        rd_addr   = r_idx[IW-1:0];
        mem_we    = 1'b0;
        wr_addr   = r_idx[IW-1:0];
        wr_key    = r_key;
        wr_cnt    = r_rd_cnt;
        div_start = 1'b0;
        div_dvd   = DVD_W'(r_rnd);
        unique case (r_state)
            wrb_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_operation;
                    n_key    = KEY_BITS'(i_item_key);
                    n_amt    = i_amount;
                    n_rnd    = i_random_value;
                    n_idx    = '0;
                    n_status = wrb_pkg::ST_OK;
                    n_picked = '0;
                    n_pct    = '0;
                end
            end
            wrb_pkg::S_CHECK: begin
                case (r_op)
                    wrb_pkg::OP_ADD: begin
                        if (amt_bad) n_status = wrb_pkg::ST_INVALID;
                    end
                    wrb_pkg::OP_DEL: begin
                        if (amt_bad) n_status = wrb_pkg::ST_INVALID;
                        else if (r_used == '0) n_status = wrb_pkg::ST_EMPTY;
                    end
                    wrb_pkg::OP_CLEAR: begin
                        n_used  = '0;
                        n_total = '0;
                    end
                    wrb_pkg::OP_QUERY: begin
                        if (tab_empty) n_status = wrb_pkg::ST_EMPTY;
                    end
                    wrb_pkg::OP_PICK: begin
                        if (tab_empty) n_status = wrb_pkg::ST_EMPTY;
                        else div_start = 1'b1;
                    end
                    default: n_status = wrb_pkg::ST_INVALID;
                endcase
            end
            wrb_pkg::S_SRD: begin
                // end of table: key absent
                if (at_end) begin
                    case (r_op) inside
                        wrb_pkg::OP_ADD: begin
                            if (r_used == UW'(ENTRIES) || amt_x > cmax_x) begin
                                n_status = wrb_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                wr_addr = r_used[IW-1:0];
                                wr_cnt  = COUNT_BITS'(r_amt);
                                n_used  = r_used + 1'b1;
                                n_total = r_total + TOT_W'(r_amt);
                            end
                        end
                        wrb_pkg::OP_DEL, wrb_pkg::OP_QUERY:
                            n_status = wrb_pkg::ST_NOTFOUND;
                        default: ;
                    endcase
                end
            end
            wrb_pkg::S_SCMP: begin
                if (r_op == wrb_pkg::OP_PICK) begin
                    if (pick_hit) begin
                        n_picked = r_rd_key;
                    end else begin
                        n_rem = r_rem - cnt_t;
                        n_idx = idx_inc;
                    end
                end else if (!key_hit) begin
                    n_idx = idx_inc;
                end else begin
                    case (r_op)
                        wrb_pkg::OP_ADD: begin
                            if (sum_x > cmax_x) begin
                                n_status = wrb_pkg::ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                wr_cnt  = COUNT_BITS'(sum_x);
                                n_total = r_total + TOT_W'(r_amt);
                            end
                        end
                        wrb_pkg::OP_DEL: begin
                            if (amt_x > cnt_x) begin
                                n_status = wrb_pkg::ST_INVALID;
                            end else begin
                                n_total = r_total - TOT_W'(r_amt);
                                if (amt_x != cnt_x) begin
                                    mem_we = 1'b1;
                                    wr_cnt = COUNT_BITS'(cnt_x - amt_x);
                                end
                            end
                        end
                        wrb_pkg::OP_QUERY: begin
                            div_start = 1'b1;
                            div_dvd   = DVD_W'(product);
                        end
                        default: ;
                    endcase
                end
            end
            wrb_pkg::S_SHR: begin
                // move the later entries up by one
                rd_addr = idx_inc[IW-1:0];
                if (idx_inc >= r_used) n_used = r_used - 1'b1;
            end
            wrb_pkg::S_SHW: begin
                mem_we = 1'b1;
                wr_key = r_rd_key;
                wr_cnt = r_rd_cnt;
                n_idx  = idx_inc;
            end
            wrb_pkg::S_MOD: begin
                if (div_done) begin
                    n_rem = div_rem;
                    n_idx = '0;
                end
            end
            wrb_pkg::S_DIV: begin
                if (div_done) n_pct = div_quo[wrb_pkg::PCT_W-1:0];
            end
            wrb_pkg::S_OUT: ;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrb_pkg::S_IDLE;
            r_used  <= '0;
            r_total <= '0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_total <= n_total;
        end
    end

    // item payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_amt    <= n_amt;
        r_rnd    <= n_rnd;
        r_idx    <= n_idx;
        r_rem    <= n_rem;
        r_status <= n_status;
        r_picked <= n_picked;
        r_pct    <= n_pct;
    end

    // table memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[wr_addr] <= wr_key;
            mem_cnt[wr_addr] <= wr_cnt;
        end
        r_rd_key <= mem_key[rd_addr];
        r_rd_cnt <= mem_cnt[rd_addr];
    end

    wrb_div #(
        .DVD_W(DVD_W),
        .DSR_W(TOT_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dvd),
        .i_divisor   (r_total),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign o_ready         = (r_state == wrb_pkg::S_IDLE);
    assign o_valid         = (r_state == wrb_pkg::S_OUT);
    assign o_status        = r_status;
    assign o_picked_key    = wrb_pkg::KEYIN_W'(r_picked);
    assign o_percent_fixed = r_pct;
    assign o_total_count   = wrb_pkg::TOTOUT_W'(r_total);

    // checks
    `WRB_ASSERT(a_no_ready_with_result, i_clk, i_rst_n, !(o_valid && o_ready), "ready while result pending")
    `WRB_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready, "ready right after accept")
    `WRB_ASSERT(a_used_in_range, i_clk, i_rst_n, r_used <= UW'(ENTRIES), "table fill past depth")
    `WRB_ASSERT(a_total_tracks_used, i_clk, i_rst_n, (r_used == '0) |-> (r_total == '0), "total and fill disagree")

endmodule
